/* src/chaikin_pkg.sv */
// Shared types and constants for the Chaikin closed-contour pass.
// Used by the front, queue, back and top-level modules; no dependencies.
package chaikin_pkg;

    // Coordinate and threshold widths
    localparam int COORD_BITS  = 12;
    localparam int THRESH_BITS = 13;
    localparam int QSUM_BITS   = COORD_BITS + 2;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int D2_BITS     = SQ_BITS + 1;
    localparam int T2_BITS     = 2 * THRESH_BITS;
    localparam int CMP_BITS    = (D2_BITS > T2_BITS) ? D2_BITS : T2_BITS;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Register port
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam int RIDX_BITS = ADDR_BITS - 2;
    localparam logic [RIDX_BITS-1:0] REG_SHORT_THRESH = RIDX_BITS'(0);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   contour_end;
    } point_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   item_done;
        logic   contour_done;
    } result_t;

    // Kind of work one accepted point hands to the back end
    typedef enum logic [1:0] {
        JOB_SINGLE,  // lone point: emit it as is
        JOB_PAIR,    // cut pair (a, b)
        JOB_CLOSE    // cut (a, b), then closing pair (b, c)
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        coord_t    a_x;
        coord_t    a_y;
        coord_t    b_x;
        coord_t    b_y;
        coord_t    c_x;
        coord_t    c_y;
    } job_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* src/chaikin_front.sv */
// Front end: accepts contour points, tracks first/previous point, issues jobs.
// Depends on chaikin_pkg.
module chaikin_front
    import chaikin_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          point_valid,
    output logic          point_ready,
    input  point_t        point,
    input  queue_status_t qstat,
    output logic          push,
    output job_t          push_job
);

    logic   started_reg, started_next;
    coord_t first_x_reg, first_x_next;
    coord_t first_y_reg, first_y_next;
    coord_t prev_x_reg,  prev_x_next;
    coord_t prev_y_reg,  prev_y_next;
    logic   accept;

    assign point_ready = !qstat.full;
    assign accept      = point_valid && point_ready;

    // Classify the request and build its job
    always_comb
    begin
        started_next = started_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        push         = 1'b0;
        push_job.kind = JOB_PAIR;
        push_job.a_x  = prev_x_reg;
        push_job.a_y  = prev_y_reg;
        push_job.b_x  = point.point_x;
        push_job.b_y  = point.point_y;
        push_job.c_x  = first_x_reg;
        push_job.c_y  = first_y_reg;
        if (accept)
        begin
            prev_x_next = point.point_x;
            prev_y_next = point.point_y;
            if (!started_reg)
            begin
                first_x_next = point.point_x;
                first_y_next = point.point_y;
                if (point.contour_end)
                begin
                    // lone point: pair it with itself
                    push          = 1'b1;
                    push_job.kind = JOB_SINGLE;
                    push_job.a_x  = point.point_x;
                    push_job.a_y  = point.point_y;
                end
                else
                begin
                    started_next = 1'b1;
                end
            end
            else
            begin
                push = 1'b1;
                if (point.contour_end)
                begin
                    push_job.kind = JOB_CLOSE;
                    started_next  = 1'b0;
                end
            end
        end
    end

    // Hold contour control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
        end
    end

    // Hold first and previous point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
        end
    end

endmodule

/* src/chaikin_queue.sv */
// Short job queue that decouples the front end from the back end.
// Depends on chaikin_pkg.
module chaikin_queue
    import chaikin_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output queue_status_t qstat,
    output logic          head_valid,
    output job_t          head_job
);

    job_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg,  count_next;
    logic                 do_push, do_pop;

    assign qstat.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_valid  = !qstat.empty;
    assign head_job    = entry_reg[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store job entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/chaikin_back.sv */
// Back end: expands jobs into point pairs, cuts corners, emits results.
// Depends on chaikin_pkg; fed by chaikin_queue.
module chaikin_back
    import chaikin_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  job_t                 head_job,
    output logic                 pop,
    input  logic [T2_BITS-1:0]   thresh_sq,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    // floor((3a + b) / 4)
    function automatic coord_t quarter(input coord_t a, input coord_t b);
        logic [QSUM_BITS-1:0] s;
        s = QSUM_BITS'(a) + QSUM_BITS'({a, 1'b0}) + QSUM_BITS'(b);
        return s[QSUM_BITS-1:2];
    endfunction

    // (q + r) / 2 rounded half to even
    function automatic coord_t half_even(input coord_t q, input coord_t r);
        logic [COORD_BITS:0] s;
        coord_t              m;
        s = (COORD_BITS+1)'(q) + (COORD_BITS+1)'(r);
        m = s[COORD_BITS:1];
        if (s[0] && m[0])
        begin
            m = m + 1'b1;
        end
        return m;
    endfunction

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Pair generator
    logic   gen_phase_reg, gen_phase_next;
    coord_t pa_x, pa_y, pb_x, pb_y;
    logic   p_item, p_contour;
    logic   gen_fire;

    // Stage 1: quarter points and differences
    logic   s1_valid_reg;
    coord_t s1_qx_reg, s1_qy_reg, s1_rx_reg, s1_ry_reg;
    coord_t s1_dx_reg, s1_dy_reg;
    logic   s1_item_reg, s1_contour_reg;

    // Stage 2: squared differences
    logic               s2_valid_reg;
    coord_t             s2_qx_reg, s2_qy_reg, s2_rx_reg, s2_ry_reg;
    logic [SQ_BITS-1:0] s2_sqx_reg, s2_sqy_reg;
    logic               s2_item_reg, s2_contour_reg;

    // Stage 3: merge decision, emitter
    logic   s3_valid_reg;
    logic   s3_phase_reg;
    logic   s3_merge_reg;
    coord_t s3_p0x_reg, s3_p0y_reg, s3_p1x_reg, s3_p1y_reg;
    logic   s3_item_reg, s3_contour_reg;

    // Output register
    logic    out_valid_reg;
    result_t out_reg;

    logic                out_free, out_load, s3_leave;
    logic                s3_free, s2_free, s1_free;
    logic                s1_move, s2_move;
    logic [D2_BITS-1:0]  d2;
    logic                merge;
    result_t             out_next;

    // Expand the head job into the pair for this cycle
    always_comb
    begin
        pa_x      = head_job.a_x;
        pa_y      = head_job.a_y;
        pb_x      = head_job.b_x;
        pb_y      = head_job.b_y;
        p_item    = 1'b1;
        p_contour = 1'b0;
        case (head_job.kind)
            JOB_SINGLE:
            begin
                pb_x      = head_job.a_x;
                pb_y      = head_job.a_y;
                p_contour = 1'b1;
            end
            JOB_PAIR:
            begin
                p_item = 1'b1;
            end
            JOB_CLOSE:
            begin
                if (gen_phase_reg)
                begin
                    pa_x      = head_job.b_x;
                    pa_y      = head_job.b_y;
                    pb_x      = head_job.c_x;
                    pb_y      = head_job.c_y;
                    p_contour = 1'b1;
                end
                else
                begin
                    p_item = 1'b0;
                end
            end
            default:
            begin
                p_item = 1'b1;
            end
        endcase
    end

    // Stall chain from the output back to the generator
    assign out_free = !out_valid_reg || result_ready;
    assign out_load = s3_valid_reg && out_free;
    assign s3_leave = out_load && (s3_merge_reg || s3_phase_reg);
    assign s3_free  = !s3_valid_reg || s3_leave;
    assign s2_move  = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign gen_fire = head_valid && s1_free;
    assign pop      = gen_fire && ((head_job.kind != JOB_CLOSE) || gen_phase_reg);

    always_comb
    begin
        gen_phase_next = gen_phase_reg;
        if (gen_fire && (head_job.kind == JOB_CLOSE))
        begin
            gen_phase_next = !gen_phase_reg;
        end
    end

    // Squared distance against squared threshold
    assign d2    = D2_BITS'(s2_sqx_reg) + D2_BITS'(s2_sqy_reg);
    assign merge = CMP_BITS'(d2) <= CMP_BITS'(thresh_sq);

    // Pick the next result: merged or Q first, then R
    always_comb
    begin
        if (s3_phase_reg)
        begin
            out_next.out_x        = s3_p1x_reg;
            out_next.out_y        = s3_p1y_reg;
            out_next.item_done    = s3_item_reg;
            out_next.contour_done = s3_contour_reg;
        end
        else
        begin
            out_next.out_x        = s3_p0x_reg;
            out_next.out_y        = s3_p0y_reg;
            out_next.item_done    = s3_merge_reg && s3_item_reg;
            out_next.contour_done = s3_merge_reg && s3_contour_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_phase_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_phase_reg <= gen_phase_next;
            if (s1_free)
            begin
                s1_valid_reg <= gen_fire;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_move;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_move;
                s3_phase_reg <= 1'b0;
            end
            else if (out_load)
            begin
                s3_phase_reg <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= out_load;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            s1_qx_reg      <= quarter(pa_x, pb_x);
            s1_qy_reg      <= quarter(pa_y, pb_y);
            s1_rx_reg      <= quarter(pb_x, pa_x);
            s1_ry_reg      <= quarter(pb_y, pa_y);
            s1_dx_reg      <= abs_diff(quarter(pa_x, pb_x), quarter(pb_x, pa_x));
            s1_dy_reg      <= abs_diff(quarter(pa_y, pb_y), quarter(pb_y, pa_y));
            s1_item_reg    <= p_item;
            s1_contour_reg <= p_contour;
        end
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_qx_reg      <= s1_qx_reg;
            s2_qy_reg      <= s1_qy_reg;
            s2_rx_reg      <= s1_rx_reg;
            s2_ry_reg      <= s1_ry_reg;
            s2_sqx_reg     <= SQ_BITS'(s1_dx_reg) * SQ_BITS'(s1_dx_reg);
            s2_sqy_reg     <= SQ_BITS'(s1_dy_reg) * SQ_BITS'(s1_dy_reg);
            s2_item_reg    <= s1_item_reg;
            s2_contour_reg <= s1_contour_reg;
        end
    end

    // Stage 3 payload
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_merge_reg   <= merge;
            s3_p0x_reg     <= merge ? half_even(s2_qx_reg, s2_rx_reg) : s2_qx_reg;
            s3_p0y_reg     <= merge ? half_even(s2_qy_reg, s2_ry_reg) : s2_qy_reg;
            s3_p1x_reg     <= s2_rx_reg;
            s3_p1y_reg     <= s2_ry_reg;
            s3_item_reg    <= s2_item_reg;
            s3_contour_reg <= s2_contour_reg;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Second result of a pair only follows an unmerged pair
    a_phase_unmerged: assert property (@(posedge clk) disable iff (!rst_n)
        s3_phase_reg |-> (s3_valid_reg && !s3_merge_reg))
        else $error("emitter in second phase on a merged pair");

    // Contour end is always also the end of its item
    a_contour_item: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.contour_done) |-> result.item_done)
        else $error("contour_done without item_done");

    // Closing phase only while a closing job sits at the head
    a_close_phase: assert property (@(posedge clk) disable iff (!rst_n)
        gen_phase_reg |-> (head_valid && (head_job.kind == JOB_CLOSE)))
        else $error("generator phase set without closing job");

    // Pop only on a completed job
    a_pop_fire: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (gen_fire && head_valid))
        else $error("job popped without issuing its pair");

endmodule

/* src/chaikin_closed_contour_pass.sv */
// Top level of the Chaikin closed-contour pass: register port, front, queue, back.
// Depends on chaikin_pkg, chaikin_front, chaikin_queue and chaikin_back.
//
//  port group  | direction | carries
//  ------------+-----------+-------------------------------------------
//  point_*     | in        | contour points (x, y, contour_end)
//  result_*    | out       | smoothed points (x, y, item_done, contour_done)
//  p*          | in/out    | register access, short_thresh at offset 0
//
// A point is taken every cycle while the 4-entry job queue has room. The
// back end issues at most one result per cycle and stalls while the output
// is held; a contour point gives one result if its cut points merge, else
// two, and the closing point up to four. Each back stage holds while the
// stage after it is full; the queue absorbs the difference. Reset clears
// contour state, queue and pipeline; short_thresh resets to 0.
module chaikin_closed_contour_pass
    import chaikin_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_ready,
    input  point_t               point,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic [THRESH_BITS-1:0] thresh_reg, thresh_next;
    logic [T2_BITS-1:0]     thresh_sq_reg;
    logic [RIDX_BITS-1:0]   reg_idx;
    logic                   cfg_write;

    queue_status_t qstat;
    logic          push, pop, head_valid;
    job_t          push_job, head_job;

    // Register port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_write && (reg_idx == REG_SHORT_THRESH))
        begin
            thresh_next = pwdata[THRESH_BITS-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx == REG_SHORT_THRESH)
        begin
            prdata = DATA_BITS'(thresh_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Hold threshold and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= '0;
            thresh_sq_reg <= '0;
        end
        else
        begin
            thresh_reg    <= thresh_next;
            thresh_sq_reg <= T2_BITS'(thresh_reg) * T2_BITS'(thresh_reg);
        end
    end

    chaikin_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .qstat       (qstat),
        .push        (push),
        .push_job    (push_job)
    );

    chaikin_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .qstat      (qstat),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    chaikin_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .thresh_sq    (thresh_sq_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
